// ===== design/tbre_pkg.sv =====
package tbre_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int MAX_RUN = 255;
  localparam int RUN_BITS = $clog2(MAX_RUN + 1);
  localparam int CMP_BITS = (PIXEL_BITS > 8) ? PIXEL_BITS : 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QLVL_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_BYTES = 3;

  localparam logic [7:0] THRESHOLD_RESET = 8'd127;
  localparam logic [0:0] REG_THRESHOLD = 1'b0;

  typedef struct packed {
    logic [1:0]                 count;
    logic                       last;
    logic [MAX_BYTES-1:0][7:0]  bytes;
  } tbre_record_t;

endpackage

// ===== design/tbre_pixel_if.sv =====
interface tbre_pixel_if import tbre_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;
  logic                  last_pixel;

  modport source (output valid, output pixel, output last_pixel, input ready);
  modport sink (input valid, input pixel, input last_pixel, output ready);
endinterface

// ===== design/tbre_code_if.sv =====
interface tbre_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_byte;

  modport source (output valid, output code_byte, output last_byte, input ready);
  modport sink (input valid, input code_byte, input last_byte, output ready);
endinterface

// ===== design/threshold_binary_rle_encoder.sv =====
// Thresholds grey pixels to bits and run-length codes them: per image, the
// starting bit value, then alternating run lengths (capped runs emit the cap
// and a zero-length run of the other value), the final length marked last.
// A pixel is taken every cycle while the four-record queue between the
// classifier and the byte serialiser has room; the byte port sends one byte
// a cycle while the receiver is ready, and the queue absorbs the bursts of
// a pixel that produces two or three bytes. The threshold
// register (address 0, reset 127) is written over the APB port; the user
// must write it only while the block is idle, which the block itself does not enforce.
module threshold_binary_rle_encoder import tbre_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tbre_pixel_if.sink  pixels,
  tbre_code_if.source codes
);

  logic [7:0]   threshold;
  logic         full;
  logic         push;
  tbre_record_t record;
  logic         pop;
  tbre_record_t head;
  logic         empty;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_THRESHOLD) ? {24'd0, threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == REG_THRESHOLD)) begin
      threshold <= pwdata[7:0];
    end
  end

  tbre_front u_front (
    .clk       (clk),
    .rst       (rst),
    .threshold (threshold),
    .pixels    (pixels),
    .full      (full),
    .push      (push),
    .record    (record)
  );

  tbre_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (record),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  tbre_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .codes (codes)
  );

endmodule

// ===== design/tbre_front.sv =====
module tbre_front import tbre_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic [7:0]   threshold,
  tbre_pixel_if.sink   pixels,
  input  logic         full,
  output logic         push,
  output tbre_record_t record
);

  logic                started;
  logic                run_value;
  logic [RUN_BITS-1:0] run_length;
  logic                started_next;
  logic                run_value_next;
  logic [RUN_BITS-1:0] run_length_next;
  logic                pix_bit;
  logic                accept;

  assign pixels.ready = !full;
  assign accept = pixels.valid && pixels.ready;
  assign pix_bit = CMP_BITS'(pixels.pixel) > CMP_BITS'(threshold);

  always_comb begin
    record = '0;
    started_next = 1'b1;
    run_value_next = run_value;
    run_length_next = run_length;
    if (!started) begin
      record.bytes[0] = 8'(pix_bit);
      record.count = 2'd1;
      run_value_next = pix_bit;
      run_length_next = RUN_BITS'(1);
    end else if (pix_bit == run_value) begin
      if (run_length < RUN_BITS'(MAX_RUN)) begin
        run_length_next = run_length + RUN_BITS'(1);
      end else begin
        record.bytes[0] = 8'(MAX_RUN);
        record.bytes[1] = 8'd0;
        record.count = 2'd2;
        run_length_next = RUN_BITS'(1);
      end
    end else begin
      record.bytes[0] = 8'(run_length);
      record.count = 2'd1;
      run_value_next = pix_bit;
      run_length_next = RUN_BITS'(1);
    end
    if (pixels.last_pixel) begin
      record.bytes[record.count] = 8'(run_length_next);
      record.count = record.count + 2'd1;
      record.last = 1'b1;
      started_next = 1'b0;
      run_value_next = 1'b0;
      run_length_next = '0;
    end
  end

  assign push = accept && (record.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      run_value <= 1'b0;
      run_length <= '0;
    end else if (accept) begin
      started <= started_next;
      run_value <= run_value_next;
      run_length <= run_length_next;
    end
  end

endmodule

// ===== design/tbre_queue.sv =====
module tbre_queue import tbre_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  tbre_record_t push_data,
  output logic         full,
  input  logic         pop,
  output tbre_record_t head,
  output logic         empty
);

  tbre_record_t         entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QLVL_BITS-1:0] level;

  assign full = (level == QLVL_BITS'(QUEUE_DEPTH));
  assign empty = (level == '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        level <= level + QLVL_BITS'(1);
      end else if (pop && !push) begin
        level <= level - QLVL_BITS'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
      level <= QLVL_BITS'(QUEUE_DEPTH))
    else $error("queue level out of range");
  a_record_count: assert property (@(posedge clk) disable iff (rst)
      push |-> (push_data.count != 2'd0))
    else $error("empty record pushed");
`endif

endmodule

// ===== design/tbre_back.sv =====
module tbre_back import tbre_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  tbre_record_t head,
  input  logic         empty,
  output logic         pop,
  tbre_code_if.source  codes
);

  logic [1:0] idx;
  logic       load;
  logic       final_byte;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;

  assign load = !empty && (!out_valid || codes.ready);
  assign final_byte = (idx == head.count - 2'd1);
  assign pop = load && final_byte;

  assign codes.valid = out_valid;
  assign codes.code_byte = out_byte;
  assign codes.last_byte = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx <= final_byte ? 2'd0 : idx + 2'd1;
      end else if (codes.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head.bytes[idx];
      out_last <= head.last && final_byte;
    end
  end

`ifndef ASSERT_OFF
  a_idx_in_record: assert property (@(posedge clk) disable iff (rst)
      !empty |-> (idx < head.count))
    else $error("byte index beyond record");
  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
      empty |-> (idx == 2'd0))
    else $error("byte index not cleared between records");
  a_last_pops: assert property (@(posedge clk) disable iff (rst)
      (load && head.last && final_byte) |-> pop)
    else $error("final byte sent without releasing record");
`endif

endmodule

// ===== tb/threshold_binary_rle_encoder_test.sv =====
`timescale 1ns / 100ps

module threshold_binary_rle_encoder_test;
  import tbre_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int SETTLE_CYCLES = 10;
  localparam int LONG_HOLD = 200;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DIR_ROWS = 11;
  localparam logic [0:0] NO_REG = ~REG_THRESHOLD;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
    logic [8:0] reps;
    logic [1:0] typed_n;
    logic [8:0] w0;
    logic [8:0] w1;
  } pix_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tbre_pixel_if pix_bus ();
  tbre_code_if  code_bus ();

  threshold_binary_rle_encoder dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pixels  (pix_bus),
    .codes   (code_bus)
  );

  logic [7:0] thr_model = THRESHOLD_RESET;
  logic       img_open = 1'b0;
  logic       run_bit = 1'b0;
  logic [7:0] run_len = 8'd0;

  logic [8:0] code_q [$];
  pix_row_t   dir_rows [DIR_ROWS];
  int         mismatches = 0;
  int         cycle_count = 0;
  int         hold_req = 0;
  bit         idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[threshold_binary_rle_encoder] ERROR");
    $finish;
  end

  task automatic report(input string what);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic int encode_pixel(input logic [7:0] pix, input logic lst,
                                      output logic [2:0][8:0] outs);
    int   n;
    logic b;
    n = 0;
    outs = '0;
    b = (pix > thr_model);
    if (!img_open) begin
      outs[n] = {8'd0, b};
      n++;
      img_open = 1'b1;
      run_bit = b;
      run_len = 8'd1;
    end else if (b == run_bit) begin
      if (run_len < MAX_RUN) begin
        run_len++;
      end else begin
        outs[n] = {1'b0, 8'(MAX_RUN)};
        n++;
        outs[n] = 9'd0;
        n++;
        run_len = 8'd1;
      end
    end else begin
      outs[n] = {1'b0, run_len};
      n++;
      run_bit = b;
      run_len = 8'd1;
    end
    if (lst) begin
      outs[n] = {1'b1, run_len};
      n++;
      img_open = 1'b0;
      run_bit = 1'b0;
      run_len = 8'd0;
    end
    return n;
  endfunction

  task automatic send_pixel(input logic [7:0] pix, input logic lst, input logic [1:0] typed_n,
                            input logic [8:0] w0, input logic [8:0] w1);
    int               gap;
    int               n;
    logic [2:0][8:0]  outs;
    gap = pick_gap();
    if (gap > 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.pixel <= pix;
    pix_bus.last_pixel <= lst;
    do @(posedge clk); while (!pix_bus.ready);
    n = encode_pixel(pix, lst, outs);
    if (typed_n == 2'd0) begin
      for (int j = 0; j < n; j++) code_q.push_back(outs[j]);
    end else begin
      code_q.push_back(w0);
      if (typed_n > 2'd1) code_q.push_back(w1);
    end
  endtask

  task automatic drain_codes();
    pix_bus.valid <= 1'b0;
    while (code_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [0:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == REG_THRESHOLD) thr_model = data[7:0];
    // read back through a second request
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_THRESHOLD;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== thr_model)
      report($sformatf("threshold read %0d, want %0d", prdata[7:0], thr_model));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_images(input int count);
    int         sent;
    int         len;
    int         left;
    int         run;
    logic       b;
    logic       noisy;
    logic [7:0] pix;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 10);
      if (len > count - sent) len = count - sent;
      noisy = ($urandom_range(0, 4) == 0);
      b = 1'($urandom_range(0, 1));
      left = len;
      while (left > 0) begin
        run = ($urandom_range(0, 6) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        if (run > left) run = left;
        for (int k = 0; k < run; k++) begin
          if (noisy || (b && thr_model == 8'd255)) begin
            pix = 8'($urandom_range(0, 255));
          end else if (b) begin
            pix = ($urandom_range(0, 3) == 0) ? thr_model + 8'd1
                                              : 8'($urandom_range(int'(thr_model) + 1, 255));
          end else begin
            pix = ($urandom_range(0, 3) == 0) ? thr_model
                                              : 8'($urandom_range(0, int'(thr_model)));
          end
          left--;
          sent++;
          send_pixel(pix, left == 0, 2'd0, 9'd0, 9'd0);
        end
        b = ~b;
      end
    end
  endtask

  initial begin : code_sink
    int         stall_left;
    logic [8:0] want;
    stall_left = 0;
    code_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && code_bus.valid && code_bus.ready) begin
        if (code_q.size() == 0) begin
          report($sformatf("unexpected code byte %0d last %0b",
                           code_bus.code_byte, code_bus.last_byte));
        end else begin
          want = code_q.pop_front();
          if (code_bus.code_byte !== want[7:0])
            report($sformatf("code byte %0d, want %0d", code_bus.code_byte, want[7:0]));
          if (code_bus.last_byte !== want[8])
            report($sformatf("last byte %0b, want %0b", code_bus.last_byte, want[8]));
        end
      end
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        code_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        code_bus.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin : pixel_source
    pix_row_t row;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_THRESHOLD;
    pwdata <= 32'd0;
    pix_bus.valid <= 1'b0;
    pix_bus.pixel <= '0;
    pix_bus.last_pixel <= 1'b0;
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    dir_rows = '{
      '{8'd255, 1'b1, 9'd1,   2'd2, {1'b0, 8'd1}, {1'b1, 8'd1}},
      '{8'd0,   1'b1, 9'd1,   2'd2, {1'b0, 8'd0}, {1'b1, 8'd1}},
      '{8'd127, 1'b0, 9'd1,   2'd1, {1'b0, 8'd0}, 9'd0},
      '{8'd128, 1'b0, 9'd1,   2'd0, 9'd0, 9'd0},
      '{8'd128, 1'b0, 9'd1,   2'd0, 9'd0, 9'd0},
      '{8'd127, 1'b1, 9'd1,   2'd0, 9'd0, 9'd0},
      '{8'd50,  1'b0, 9'd255, 2'd0, 9'd0, 9'd0},
      '{8'd0,   1'b1, 9'd1,   2'd0, 9'd0, 9'd0},
      '{8'd200, 1'b0, 9'd1,   2'd0, 9'd0, 9'd0},
      '{8'hAA,  1'b0, 9'd3,   2'd0, 9'd0, 9'd0},
      '{8'h55,  1'b1, 9'd1,   2'd0, 9'd0, 9'd0}
    };
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      for (int k = 0; k < int'(row.reps); k++)
        send_pixel(row.pixel, row.last, (k == 0) ? row.typed_n : 2'd0, row.w0, row.w1);
    end
    drain_codes();

    reg_write(REG_THRESHOLD, {24'($urandom()), 8'd0});
    run_images(35);
    drain_codes();

    reg_write(REG_THRESHOLD, {24'($urandom()), 8'd255});
    run_images(35);
    drain_codes();

    reg_write(REG_THRESHOLD, {24'($urandom()), 8'($urandom_range(1, 254))});
    hold_req = LONG_HOLD;
    run_images(18);
    drain_codes();
    run_images(17);
    drain_codes();

    idle_on = 1'b0;
    reg_write(REG_THRESHOLD, $urandom());
    run_images(35);
    drain_codes();
    idle_on = 1'b1;

    reg_write(NO_REG, $urandom());
    run_images(35);
    drain_codes();

    reg_write(REG_THRESHOLD, {24'($urandom()), 8'd1});
    run_images(35);
    drain_codes();

    if (code_q.size() != 0) report($sformatf("%0d code bytes never arrived", code_q.size()));
    if (mismatches == 0) begin
      $display("[threshold_binary_rle_encoder] OK");
    end else begin
      $display("[threshold_binary_rle_encoder] ERROR");
    end
    $finish;
  end

endmodule

// ===== threshold_binary_rle_encoder.f =====
design/tbre_pkg.sv
design/tbre_pixel_if.sv
design/tbre_code_if.sv
design/tbre_front.sv
design/tbre_queue.sv
design/tbre_back.sv
design/threshold_binary_rle_encoder.sv
tb/threshold_binary_rle_encoder_test.sv
